/* sv/rds_pkg.sv */
// ----------------------------------------------------------------------------
// rds_pkg
// Shared sizes, register indexes and helpers for the 2x2 RGB downscaler.
// ----------------------------------------------------------------------------
package rds_pkg;

    // Pixel format.
    localparam int CH_BITS  = 8;
    localparam int NUM_CH   = 3;
    localparam int PAIR_BITS = CH_BITS + 1;
    localparam int QUAD_BITS = CH_BITS + 2;

    // Frame limits.
    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int LINE_DEPTH     = MAX_WIDTH / 2;
    localparam int LINE_ADDR_BITS = $clog2(LINE_DEPTH);
    localparam int LINE_BITS      = NUM_CH * PAIR_BITS;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(MAX_HEIGHT);

    // Configuration registers.
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = HEIGHT_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(512);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(512);

    typedef logic [CH_BITS-1:0] chan_t;

    // Rounded mean of a stored pair sum and the current pair.
    function automatic chan_t quad_mean(input logic [PAIR_BITS-1:0] pair,
                                        input chan_t left,
                                        input chan_t right);
        logic [QUAD_BITS-1:0] sum;
        sum = QUAD_BITS'(pair) + QUAD_BITS'(left) + QUAD_BITS'(right) + QUAD_BITS'(2);
        return sum[QUAD_BITS-1:2];
    endfunction

endpackage

/* sv/rgb_downscale_2x2_average.sv */
// ----------------------------------------------------------------------------
// rgb_downscale_2x2_average
// Halves an RGB888 raster stream in width and height with a rounded 2x2 box
// average. Pair sums of even rows are kept in a line RAM.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Beat contents
//  --------+-----------+----------------------+---------------------------------
//  input   | sink      | in_valid / in_stall  | in_ch0, in_ch1, in_ch2
//  output  | source    | out_valid / out_stall| out_ch0..2, row_end, frame_end
//  config  | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One source pixel is taken per clock while in_stall is low; the result of a
// block enters the result register as the input register passes on its last
// pixel, which an output stall can delay. The rate is set by the single line
// RAM write port and read port, each used at most once per beat.
// Reset leaves the line RAM uncleared; every entry is written on an even row
// before it is read, so no clearing pass is needed.
// An output stall holds the result register and stalls the input only when
// the pixel in the input register has a result to deliver.
module rgb_downscale_2x2_average (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rds_pkg::CH_BITS-1:0]        in_ch0,
    input  logic [rds_pkg::CH_BITS-1:0]        in_ch1,
    input  logic [rds_pkg::CH_BITS-1:0]        in_ch2,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rds_pkg::CH_BITS-1:0]        out_ch0,
    output logic [rds_pkg::CH_BITS-1:0]        out_ch1,
    output logic [rds_pkg::CH_BITS-1:0]        out_ch2,
    output logic                               row_end,
    output logic                               frame_end,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rds_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import rds_pkg::*;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LEFT,
        KIND_STORE,
        KIND_EMIT
    } kind_t;

    // Configuration and frame position.
    logic [WIDTH_BITS-1:0]     width_reg;
    logic [HEIGHT_BITS-1:0]    height_reg;
    logic [COL_BITS-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0]       row_reg, row_next;
    logic [WIDTH_BITS-1:0]     width_eff, kept_width, col_inc;
    logic [HEIGHT_BITS-1:0]    height_eff, kept_height, row_inc;
    logic                      cfg_write;

    // Input register.
    logic                      s1_valid_reg;
    kind_t                     s1_kind_reg;
    chan_t                     s1_px_reg [NUM_CH];
    logic [LINE_ADDR_BITS-1:0] s1_addr_reg;
    logic                      s1_last_col_reg, s1_last_row_reg;
    kind_t                     acc_kind;
    logic                      acc_last_col, acc_last_row;

    // Left pixel of the current pair.
    chan_t                     left_reg [NUM_CH];

    // Result register.
    logic                      out_valid_reg;
    chan_t                     out_px_reg [NUM_CH];
    logic                      row_end_reg, frame_end_reg;

    // Handshake.
    logic                      in_accept, s1_advance, out_free;

    // Line RAM.
    logic                      ram_we, ram_re;
    logic [LINE_BITS-1:0]      ram_wdata, ram_rdata;
    chan_t                     in_px [NUM_CH];

    assign in_px[0] = in_ch0;
    assign in_px[1] = in_ch1;
    assign in_px[2] = in_ch2;

    // Effective frame size, clamped to the supported range.
    always_comb
    begin
        if (width_reg < WIDTH_BITS'(2))
        begin
            width_eff = WIDTH_BITS'(2);
        end
        else if (width_reg > WIDTH_BITS'(MAX_WIDTH))
        begin
            width_eff = WIDTH_BITS'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_reg;
        end
        if (height_reg < HEIGHT_BITS'(2))
        begin
            height_eff = HEIGHT_BITS'(2);
        end
        else if (height_reg > HEIGHT_BITS'(MAX_HEIGHT))
        begin
            height_eff = HEIGHT_BITS'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = height_reg;
        end
        kept_width  = {width_eff[WIDTH_BITS-1:1], 1'b0};
        kept_height = {height_eff[HEIGHT_BITS-1:1], 1'b0};
    end

    // Handshake: the input register moves on unless it holds a result that
    // cannot yet enter the result register.
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && ((s1_kind_reg != KIND_EMIT) || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;

    // Classify the arriving pixel by its position in the frame.
    always_comb
    begin
        acc_last_col = (WIDTH_BITS'(col_reg) == kept_width - WIDTH_BITS'(1));
        acc_last_row = (HEIGHT_BITS'(row_reg) == kept_height - HEIGHT_BITS'(1));
        if (WIDTH_BITS'(col_reg) >= kept_width || HEIGHT_BITS'(row_reg) >= kept_height)
        begin
            acc_kind = KIND_NONE;
        end
        else if (!col_reg[0])
        begin
            acc_kind = KIND_LEFT;
        end
        else if (!row_reg[0])
        begin
            acc_kind = KIND_STORE;
        end
        else
        begin
            acc_kind = KIND_EMIT;
        end
    end

    // Next frame position after an accepted pixel.
    always_comb
    begin
        col_inc = WIDTH_BITS'(col_reg) + WIDTH_BITS'(1);
        row_inc = HEIGHT_BITS'(row_reg) + HEIGHT_BITS'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= height_eff) ? '0 : row_inc[ROW_BITS-1:0];
        end
        else
        begin
            col_next = col_inc[COL_BITS-1:0];
        end
    end

    // Configuration registers and frame counters; a width or height write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write && cfg_index == REG_SOURCE_WIDTH)
        begin
            width_reg <= cfg_data[WIDTH_BITS-1:0];
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (cfg_write && cfg_index == REG_SOURCE_HEIGHT)
        begin
            height_reg <= cfg_data;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg     <= acc_kind;
            s1_px_reg       <= in_px;
            s1_addr_reg     <= col_reg[COL_BITS-1:1];
            s1_last_col_reg <= acc_last_col;
            s1_last_row_reg <= acc_last_row;
        end
    end

    // Left pixel of each pair; cleared when the frame restarts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                left_reg[c] <= '0;
            end
        end
        else if (cfg_write && (cfg_index == REG_SOURCE_WIDTH ||
                               cfg_index == REG_SOURCE_HEIGHT))
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                left_reg[c] <= '0;
            end
        end
        else if (s1_advance && s1_kind_reg == KIND_LEFT)
        begin
            left_reg <= s1_px_reg;
        end
    end

    // Line RAM: pair sums written on even rows, read when an odd-row pair
    // is completed.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            ram_wdata[c*PAIR_BITS +: PAIR_BITS] =
                PAIR_BITS'(left_reg[c]) + PAIR_BITS'(s1_px_reg[c]);
        end
    end

    assign ram_we = s1_advance && s1_kind_reg == KIND_STORE;
    assign ram_re = in_accept && acc_kind == KIND_EMIT;

    rds_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (col_reg[COL_BITS-1:1]),
        .rdata (ram_rdata)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_kind_reg == KIND_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_kind_reg == KIND_EMIT)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                out_px_reg[c] <= quad_mean(ram_rdata[c*PAIR_BITS +: PAIR_BITS],
                                           left_reg[c], s1_px_reg[c]);
            end
            row_end_reg   <= s1_last_col_reg;
            frame_end_reg <= s1_last_col_reg && s1_last_row_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ch0   = out_px_reg[0];
    assign out_ch1   = out_px_reg[1];
    assign out_ch2   = out_px_reg[2];
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

    // The line RAM is never written and read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("line RAM written and read in the same cycle");

    // The input side only stalls behind a pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_kind_reg == KIND_EMIT && out_valid_reg))
        else $error("input stalled without a pending result");

    // A frame ends only on the last pixel of a reduced row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> row_end)
        else $error("frame end without row end");

    // The frame position stays inside the effective frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (WIDTH_BITS'(col_reg) < width_eff) && (HEIGHT_BITS'(row_reg) < height_eff))
        else $error("frame position outside the frame");

endmodule

/* sv/rds_ram.sv */
// ----------------------------------------------------------------------------
// rds_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rds_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* tb/tb_rgb_downscale_2x2_average.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_downscale_2x2_average
// Self-checking bench for the 2x2 box-average RGB downscaler. Source pixels
// are streamed in raster order with random gaps while the output channel is
// stalled at random. A bench-side model of the averaging predicts every
// output beat, and a checker compares each one in order, field by field.
// ----------------------------------------------------------------------------
module tb_rgb_downscale_2x2_average;
    import rds_pkg::*;

    // Indexes that map to no register; writes to them must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = CFG_INDEX_BITS'(3);

    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_REPORTS      = 50;
    localparam int PIXELS_PER_PHASE = 110;

    typedef chan_t [NUM_CH-1:0] rgb_t;

    typedef struct packed {
        rgb_t mean;
        logic row_end;
        logic frame_end;
    } scaled_pixel_t;

    // Directed 4x4 frame, each entry {ch2, ch1, ch0}. The four blocks hold
    // all-zero and all-full channels, sums that round down and up, the
    // largest sums and a mixed block.
    localparam rgb_t DIRECTED_PIX [16] = '{
        24'hFFFF00, 24'h00FF00, 24'h010100, 24'h010101,
        24'h00FF00, 24'hFFFF00, 24'h010000, 24'h000000,
        24'hFEFEFF, 24'hFEFEFF, 24'hFFAA80, 24'hFF557F,
        24'hFEFFFF, 24'hFFFFFE, 24'h005501, 24'h00AAFE
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    chan_t                     in_ch0    = '0;
    chan_t                     in_ch1    = '0;
    chan_t                     in_ch2    = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    chan_t                     out_ch0;
    chan_t                     out_ch1;
    chan_t                     out_ch2;
    logic                      row_end;
    logic                      frame_end;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Predictor state: registers, frame position, held left pixel, pair sums.
    logic [WIDTH_BITS-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_BITS-1:0] height_reg = HEIGHT_RESET;
    int                     col_pos    = 0;
    int                     row_pos    = 0;
    chan_t                  held_left [NUM_CH] = '{default: '0};
    logic [PAIR_BITS-1:0]   pair_sums [LINE_DEPTH][NUM_CH];
    scaled_pixel_t          expected_means [$];

    int sender_idle_pct   = 29;
    int receiver_idle_pct = 65;
    int pixels_sent       = 0;
    int means_checked     = 0;
    int frames_seen       = 0;
    int error_count       = 0;

    rgb_downscale_2x2_average u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_ch0    (in_ch0),
        .in_ch1    (in_ch1),
        .in_ch2    (in_ch2),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_ch0   (out_ch0),
        .out_ch1   (out_ch1),
        .out_ch2   (out_ch2),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Random back-pressure on the output channel.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    // Frame size in use, after clamping.
    function automatic int used_width();
        if (width_reg < 2)
            return 2;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int used_height();
        if (height_reg < 2)
            return 2;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    // Advance the frame by one source pixel and queue the mean it completes.
    function automatic void predict_pixel(input rgb_t px);
        int            w;
        int            h;
        int            kept_w;
        int            kept_h;
        int            line_idx;
        int            quad;
        scaled_pixel_t result;
        w        = used_width();
        h        = used_height();
        kept_w   = w & ~1;
        kept_h   = h & ~1;
        line_idx = col_pos >> 1;
        if (col_pos < kept_w && row_pos < kept_h)
        begin
            if (col_pos % 2 == 0)
            begin
                for (int c = 0; c < NUM_CH; c++)
                    held_left[c] = px[c];
            end
            else if (row_pos % 2 == 0)
            begin
                for (int c = 0; c < NUM_CH; c++)
                    pair_sums[line_idx][c] = PAIR_BITS'(held_left[c]) + PAIR_BITS'(px[c]);
            end
            else
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    quad = int'(pair_sums[line_idx][c]) + int'(held_left[c]) + int'(px[c]) + 2;
                    result.mean[c] = chan_t'(quad >> 2);
                end
                result.row_end   = (col_pos == kept_w - 1);
                result.frame_end = result.row_end && (row_pos == kept_h - 1);
                expected_means.push_back(result);
            end
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    function automatic chan_t random_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one pixel beat, with random idle cycles ahead of it. in_valid is
    // left high on return so that back-to-back beats need no second update.
    task automatic send_pixel(input rgb_t px);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_ch0   <= px[0];
        in_ch1   <= px[1];
        in_ch2   <= px[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_random_pixels(input int count);
        rgb_t px;
        for (int i = 0; i < count; i++)
        begin
            for (int c = 0; c < NUM_CH; c++)
                px[c] = random_channel();
            send_pixel(px);
        end
    endtask

    // Register write, made only once every expected mean has come out and
    // the pipeline has had time to settle.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        in_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_SOURCE_WIDTH || idx == REG_SOURCE_HEIGHT)
        begin
            if (idx == REG_SOURCE_WIDTH)
                width_reg = data[WIDTH_BITS-1:0];
            else
                height_reg = data;
            col_pos = 0;
            row_pos = 0;
            for (int c = 0; c < NUM_CH; c++)
                held_left[c] = '0;
        end
    endtask

    task automatic set_frame(input int w, input int h);
        write_register(REG_SOURCE_WIDTH, CFG_DATA_BITS'(w));
        write_register(REG_SOURCE_HEIGHT, CFG_DATA_BITS'(h));
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0:
            begin
                sender_idle_pct   = 29;
                receiver_idle_pct = 65;
            end
            1:
            begin
                sender_idle_pct   = 65;
                receiver_idle_pct = 29;
            end
            default:
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
        endcase
    endtask

    // Part of the first row at the reset size gives no beat; then a width of
    // two under the reset height gives one mean per two rows and no frame end.
    task automatic test_reset_defaults();
        send_random_pixels(32);
        write_register(REG_SOURCE_WIDTH, CFG_DATA_BITS'(2));
        send_random_pixels(64);
    endtask

    // Hand-made 4x4 frame: extremes of every channel and the rounding cases.
    task automatic test_directed_means();
        set_frame(4, 4);
        foreach (DIRECTED_PIX[i])
            send_pixel(DIRECTED_PIX[i]);
    endtask

    // Odd width and height: the last column and row give no output.
    task automatic test_odd_size();
        set_frame(3, 3);
        send_random_pixels(9);
    endtask

    task automatic test_register_edges();
        // Sizes below two are clamped to two; frames follow back to back.
        set_frame(0, 1);
        send_random_pixels(8);
        set_frame(1, 0);
        send_random_pixels(4);

        // Data bits above the width register are dropped, leaving six.
        write_register(REG_SOURCE_WIDTH, CFG_DATA_BITS'(13'h1006));
        write_register(REG_SOURCE_HEIGHT, CFG_DATA_BITS'(2));
        send_random_pixels(12);

        // Writes to the spare indexes leave the frame running.
        set_frame(4, 2);
        send_random_pixels(3);
        write_register(REG_SPARE_2, '1);
        write_register(REG_SPARE_3, CFG_DATA_BITS'(13'h0AAA));
        send_random_pixels(5);

        // A real write part-way through a frame starts a new one.
        set_frame(6, 4);
        send_random_pixels(9);
        write_register(REG_SOURCE_HEIGHT, CFG_DATA_BITS'(4));
        send_random_pixels(24);
    endtask

    // Mostly whole frames of small random sizes, some cut short by a new
    // setting, a few with sizes that need clamping. Each phase sends a fixed
    // number of pixels, so its last frame may be cut short as well.
    task automatic test_random_frames(input int phase);
        int target;
        int w;
        int h;
        int frame_pixels;
        int batch;
        set_idling(phase);
        target = pixels_sent + PIXELS_PER_PHASE;
        while (pixels_sent < target)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                case ($urandom_range(0, 19))
                    0, 1:    w = $urandom_range(0, 1);
                    2, 3, 4: w = $urandom_range(13, 40);
                    default: w = $urandom_range(2, 12);
                endcase
                h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
                if ($urandom_range(0, 1) == 0)
                    set_frame(w, h);
                else
                begin
                    write_register(REG_SOURCE_HEIGHT, CFG_DATA_BITS'(h));
                    write_register(REG_SOURCE_WIDTH, CFG_DATA_BITS'(w));
                end
            end
            frame_pixels = used_width() * used_height();
            if ($urandom_range(0, 6) == 0)
                batch = $urandom_range(1, frame_pixels - 1);
            else
                batch = $urandom_range(1, 3) * frame_pixels;
            if (batch > target - pixels_sent)
                batch = target - pixels_sent;
            send_random_pixels(batch);
        end
    endtask

    // Widest setting: a width beyond the limit clamps to MAX_WIDTH, so the
    // first row is only begun and no beat is due.
    task automatic test_widest_frame();
        write_register(REG_SOURCE_WIDTH, CFG_DATA_BITS'(13'h07FF));
        write_register(REG_SOURCE_HEIGHT, CFG_DATA_BITS'(2));
        send_random_pixels(40);
    endtask

    // Tallest setting: a height beyond the limit clamps to MAX_HEIGHT, so the
    // frame is only begun and no frame end is due.
    task automatic test_tallest_frame();
        write_register(REG_SOURCE_WIDTH, CFG_DATA_BITS'(2));
        write_register(REG_SOURCE_HEIGHT, CFG_DATA_BITS'(13'h1FFF));
        send_random_pixels(40);
    endtask

    // Compare every accepted output beat with the oldest prediction.
    always @(posedge clk)
    begin
        scaled_pixel_t got;
        scaled_pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.mean      = {out_ch2, out_ch1, out_ch0};
            got.row_end   = row_end;
            got.frame_end = frame_end;
            if (expected_means.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected beat ch0=%0d ch1=%0d ch2=%0d row_end=%0b frame_end=%0b",
                             $time, got.mean[0], got.mean[1], got.mean[2],
                             got.row_end, got.frame_end);
            end
            else
            begin
                want = expected_means.pop_front();
                means_checked++;
                if (want.frame_end)
                    frames_seen++;
                if (got.mean[0] !== want.mean[0] || got.mean[1] !== want.mean[1] ||
                    got.mean[2] !== want.mean[2] || got.row_end !== want.row_end ||
                    got.frame_end !== want.frame_end)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch, expected ch0=%0d ch1=%0d ch2=%0d re=%0b fe=%0b, got ch0=%0d ch1=%0d ch2=%0d re=%0b fe=%0b",
                                 $time, want.mean[0], want.mean[1], want.mean[2],
                                 want.row_end, want.frame_end, got.mean[0], got.mean[1],
                                 got.mean[2], got.row_end, got.frame_end);
                end
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d means still awaited.", expected_means.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_means();
        test_odd_size();
        test_register_edges();
        test_random_frames(0);
        test_random_frames(1);
        test_random_frames(2);
        test_widest_frame();
        test_tallest_frame();

        // Let the last beats drain, then allow for the pipeline latency.
        in_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d source pixels over clamped, odd, widest and tallest frame sizes,",
                 pixels_sent);
        $display("checked %0d averaged pixels and %0d frame ends; %0d failures.",
                 means_checked, frames_seen, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
